FILE: rtl/mant_pkg.sv
package mant_pkg;

   localparam int DIM_W = 13;
   localparam int SLOT_FIELD_W = 11;

   localparam logic [1:0] MODE_LOAD = 2'd0;
   localparam logic [1:0] MODE_STEP = 2'd1;
   localparam logic [1:0] MODE_READ = 2'd2;

   localparam logic [1:0] HEAD_UP    = 2'd0;
   localparam logic [1:0] HEAD_RIGHT = 2'd1;
   localparam logic [1:0] HEAD_DOWN  = 2'd2;
   localparam logic [1:0] HEAD_LEFT  = 2'd3;

   localparam logic REG_GRID_WIDTH  = 1'b0;
   localparam logic REG_GRID_HEIGHT = 1'b1;

   localparam logic [9:0] GRID_WIDTH_RESET  = 10'd360;
   localparam logic [8:0] GRID_HEIGHT_RESET = 9'd175;

   typedef struct packed {
      logic [1:0]  mode;
      logic [10:0] ant_slot;
      logic [8:0]  col_in;
      logic [7:0]  row_in;
      logic [1:0]  heading_in;
   } req_type;

   typedef struct packed {
      logic [8:0] ant_col;
      logic [7:0] ant_row;
      logic [1:0] ant_heading;
      logic [8:0] cell_col;
      logic [7:0] cell_row;
      logic       cell_black;
      logic       bounced;
   } rsp_type;

   typedef struct packed {
      logic [9:0] grid_width;
      logic [8:0] grid_height;
   } grid_cfg_type;

   typedef struct packed {
      logic clearing;
      logic stepping;
   } seq_status_type;

   typedef struct packed {
      logic [8:0] col;
      logic [7:0] row;
      logic [1:0] heading;
   } ant_entry_type;

endpackage

FILE: rtl/mant_ram.sv
module mant_ram #(
   parameter int WIDTH = 19,
   parameter int DEPTH = 2048
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // forward a write that lands on the entry being read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/mant_seq.sv
module mant_seq
   import mant_pkg::*;
#(
   parameter int MAX_COLS  = 512,
   parameter int MAX_ROWS  = 256,
   parameter int ANT_SLOTS = 2048
) (
   input  logic           clock,
   input  logic           reset,
   input  grid_cfg_type   cfg,
   input  logic           start,
   output logic           busy,
   input  req_type        req_item,
   output logic           rsp_strobe,
   output rsp_type        rsp_item,
   output seq_status_type status
);

   localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int AW = (ANT_SLOTS > 1) ? $clog2(ANT_SLOTS) : 1;
   localparam int ANT_W = $bits(ant_entry_type);
   localparam logic [DIM_W-1:0] COLS_LIM = DIM_W'(MAX_COLS);
   localparam logic [DIM_W-1:0] ROWS_LIM = DIM_W'(MAX_ROWS);
   localparam logic [RW-1:0] LAST_ROW = RW'(MAX_ROWS - 1);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_ANT   = 3'd2;
   localparam logic [2:0] ST_LOOK  = 3'd3;
   localparam logic [2:0] ST_STEP  = 3'd4;

   function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] lim);
      if (v >= lim) begin
         return lim - DIM_W'(1);
      end
      return v;
   endfunction

   function automatic logic [SLOT_FIELD_W-1:0] slot_mod(input logic [SLOT_FIELD_W-1:0] s);
      logic [SLOT_FIELD_W-1:0] r;
      r = s;
      for (int k = SLOT_FIELD_W - 1; k >= 0; k--) begin
         if (((ANT_SLOTS << k) < (1 << SLOT_FIELD_W)) && (32'(r) >= (ANT_SLOTS << k))) begin
            r = r - SLOT_FIELD_W'(ANT_SLOTS << k);
         end
      end
      return r;
   endfunction

   logic [2:0]       state_ff, state_in;
   logic [RW-1:0]    clear_row_ff, clear_row_in;
   logic [1:0]       mode_ff, mode_in;
   logic [AW-1:0]    slot_ff, slot_in;
   logic [8:0]       col_ff, col_in;
   logic [7:0]       row_ff, row_in;
   logic [1:0]       head_ff, head_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   rsp_type          rsp_item_ff, rsp_item_in;

   logic [DIM_W-1:0] w_eff, h_eff;
   logic             accept;
   logic [8:0]       req_col_sat, ant_col_sat;
   logic [7:0]       req_row_sat, ant_row_sat;
   logic [AW-1:0]    req_slot;

   logic                cell_wr_en, cell_rd_en;
   logic [RW-1:0]       cell_wr_addr, cell_rd_addr;
   logic [MAX_COLS-1:0] cell_wr_data, cell_rd_data;
   logic                ant_wr_en, ant_rd_en;
   ant_entry_type       ant_wr_data, ant_rd_data;

   logic       cell_bit, new_bit, hit;
   logic [1:0] turn, new_head;
   logic [8:0] new_col;
   logic [7:0] new_row;

   always_comb begin
      if (cfg.grid_width == '0) begin
         w_eff = DIM_W'(1);
      end else if (DIM_W'(cfg.grid_width) > COLS_LIM) begin
         w_eff = COLS_LIM;
      end else begin
         w_eff = DIM_W'(cfg.grid_width);
      end
      if (cfg.grid_height == '0) begin
         h_eff = DIM_W'(1);
      end else if (DIM_W'(cfg.grid_height) > ROWS_LIM) begin
         h_eff = ROWS_LIM;
      end else begin
         h_eff = DIM_W'(cfg.grid_height);
      end
   end

   assign busy   = (state_ff == ST_CLEAR) || (state_ff == ST_ANT);
   assign accept = start && !busy;

   assign req_col_sat = 9'(sat_dim(DIM_W'(req_item.col_in), w_eff));
   assign req_row_sat = 8'(sat_dim(DIM_W'(req_item.row_in), h_eff));
   assign req_slot    = AW'(slot_mod(req_item.ant_slot));
   assign ant_col_sat = 9'(sat_dim(DIM_W'(ant_rd_data.col), w_eff));
   assign ant_row_sat = 8'(sat_dim(DIM_W'(ant_rd_data.row), h_eff));

   // turn, then move or bounce off the edge
   always_comb begin
      cell_bit = cell_rd_data[CW'(col_ff)];
      new_bit  = ~cell_bit;
      turn     = cell_bit ? (head_ff - 2'd1) : (head_ff + 2'd1);
      new_col  = col_ff;
      new_row  = row_ff;
      unique case (turn)
         HEAD_UP: begin
            hit = (row_ff == '0);
            if (!hit) new_row = row_ff - 8'd1;
         end
         HEAD_RIGHT: begin
            hit = (DIM_W'(col_ff) + DIM_W'(1)) >= w_eff;
            if (!hit) new_col = col_ff + 9'd1;
         end
         HEAD_DOWN: begin
            hit = (DIM_W'(row_ff) + DIM_W'(1)) >= h_eff;
            if (!hit) new_row = row_ff + 8'd1;
         end
         default: begin
            hit = (col_ff == '0);
            if (!hit) new_col = col_ff - 9'd1;
         end
      endcase
      new_head = hit ? (turn + 2'd2) : turn;
   end

   always_comb begin
      state_in      = state_ff;
      clear_row_in  = clear_row_ff;
      mode_in       = mode_ff;
      slot_in       = slot_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      head_in       = head_ff;
      rsp_strobe_in = 1'b0;
      rsp_item_in   = rsp_item_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clear_row_in = clear_row_ff + RW'(1);
            if (clear_row_ff == LAST_ROW) state_in = ST_IDLE;
         end
         ST_ANT: begin
            col_in   = ant_col_sat;
            row_in   = ant_row_sat;
            head_in  = ant_rd_data.heading;
            state_in = ST_STEP;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (state_ff == ST_LOOK) begin
         rsp_strobe_in = 1'b1;
         rsp_item_in   = '0;
         unique case (mode_ff)
            MODE_LOAD: begin
               rsp_item_in.ant_col     = col_ff;
               rsp_item_in.ant_row     = row_ff;
               rsp_item_in.ant_heading = head_ff;
               rsp_item_in.cell_col    = col_ff;
               rsp_item_in.cell_row    = row_ff;
               rsp_item_in.cell_black  = cell_bit;
            end
            MODE_READ: begin
               rsp_item_in.cell_col    = col_ff;
               rsp_item_in.cell_row    = row_ff;
               rsp_item_in.cell_black  = cell_bit;
            end
            default: begin
            end
         endcase
      end
      if (state_ff == ST_STEP) begin
         rsp_strobe_in           = 1'b1;
         rsp_item_in.ant_col     = new_col;
         rsp_item_in.ant_row     = new_row;
         rsp_item_in.ant_heading = new_head;
         rsp_item_in.cell_col    = col_ff;
         rsp_item_in.cell_row    = row_ff;
         rsp_item_in.cell_black  = new_bit;
         rsp_item_in.bounced     = hit;
      end
      if (accept) begin
         mode_in  = req_item.mode;
         slot_in  = req_slot;
         col_in   = req_col_sat;
         row_in   = req_row_sat;
         head_in  = req_item.heading_in;
         state_in = (req_item.mode == MODE_STEP) ? ST_ANT : ST_LOOK;
      end
   end

   always_comb begin
      cell_rd_en   = accept || (state_ff == ST_ANT);
      cell_rd_addr = (state_ff == ST_ANT) ? RW'(ant_row_sat) : RW'(req_row_sat);
      cell_wr_en   = (state_ff == ST_CLEAR) || (state_ff == ST_STEP);
      cell_wr_addr = (state_ff == ST_CLEAR) ? clear_row_ff : RW'(row_ff);
      cell_wr_data = '0;
      if (state_ff == ST_STEP) begin
         cell_wr_data = cell_rd_data;
         cell_wr_data[CW'(col_ff)] = new_bit;
      end
      ant_rd_en   = accept;
      ant_wr_en   = ((state_ff == ST_LOOK) && (mode_ff == MODE_LOAD)) || (state_ff == ST_STEP);
      ant_wr_data = (state_ff == ST_STEP) ? {new_col, new_row, new_head}
                                          : {col_ff, row_ff, head_ff};
   end

   mant_ram #(
      .WIDTH (MAX_COLS),
      .DEPTH (MAX_ROWS)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (cell_wr_en),
      .wr_addr (cell_wr_addr),
      .wr_data (cell_wr_data),
      .rd_en   (cell_rd_en),
      .rd_addr (cell_rd_addr),
      .rd_data (cell_rd_data)
   );

   mant_ram #(
      .WIDTH (ANT_W),
      .DEPTH (ANT_SLOTS)
   ) u_ant_ram (
      .clock   (clock),
      .wr_en   (ant_wr_en),
      .wr_addr (slot_ff),
      .wr_data (ant_wr_data),
      .rd_en   (ant_rd_en),
      .rd_addr (req_slot),
      .rd_data (ant_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_row_ff  <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_row_ff  <= clear_row_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      slot_ff     <= slot_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
      head_ff     <= head_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_item        = rsp_item_ff;
   assign status.clearing = (state_ff == ST_CLEAR);
   assign status.stepping = (state_ff == ST_ANT) || (state_ff == ST_STEP);

endmodule

FILE: rtl/multi_ant_langton_grid_step.sv
// Load, read and mode 3 items: busy stays low; result strobed from a register set in the
//   look state; one item per cycle.
// Step items: ant-table read, then cell-row read-modify-write; result strobed from a
//   register set in the step state; no new item is taken during the ant-table read.
// Reset is synchronous: busy stays high while each cell row is swept to white, one row a
//   cycle; register writes are taken throughout. Results cannot be stalled.
module multi_ant_langton_grid_step
   import mant_pkg::*;
#(
   parameter int MAX_COLS  = 512,
   parameter int MAX_ROWS  = 256,
   parameter int ANT_SLOTS = 2048
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_item,
   output logic        rsp_strobe,
   output rsp_type     rsp_item,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   grid_cfg_type   cfg_ff, cfg_in;
   seq_status_type status;
   logic           csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (paddr[2])
            REG_GRID_WIDTH:  cfg_in.grid_width  = pwdata[9:0];
            REG_GRID_HEIGHT: cfg_in.grid_height = pwdata[8:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_GRID_HEIGHT: prdata = 32'(cfg_ff.grid_height);
         default:         prdata = 32'(cfg_ff.grid_width);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_width  <= GRID_WIDTH_RESET;
         cfg_ff.grid_height <= GRID_HEIGHT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mant_seq #(
      .MAX_COLS  (MAX_COLS),
      .MAX_ROWS  (MAX_ROWS),
      .ANT_SLOTS (ANT_SLOTS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .status     (status)
   );

   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      status.clearing |-> !rsp_strobe)
      else $error("result strobed during the clearing sweep");

   a_quick_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_item.mode != MODE_STEP)) |-> ##2 rsp_strobe)
      else $error("load or read item gave no result");

   a_step_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_item.mode == MODE_STEP)) |=> busy ##2 rsp_strobe)
      else $error("step item gave no result");

   a_bounce_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.bounced) |->
         ((rsp_item.ant_col == rsp_item.cell_col) && (rsp_item.ant_row == rsp_item.cell_row)
          && $past(status.stepping)))
      else $error("bounced ant left its cell");

endmodule

FILE: verif/grid_step_checker.sv
`timescale 1ns / 100ps
module grid_step_checker
   import mant_pkg::*;
#(
   parameter int MAX_COLS  = 512,
   parameter int MAX_ROWS  = 256,
   parameter int ANT_SLOTS = 2048
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  req_type     req_item,
   input  logic        rsp_strobe,
   input  rsp_type     rsp_item,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic        pready,
   output int          fail_count,
   output int          pending_count,
   output int          bounce_count
);

   bit [MAX_COLS*MAX_ROWS-1:0] cell_black_map;
   ant_entry_type              ant_table [ANT_SLOTS];
   grid_cfg_type               grid_cfg;
   rsp_type                    expected_q [$];
   rsp_type                    oldest;

   function automatic int usable_dim(int v, int maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   function automatic int clamp_to(int v, int limit);
      return (v >= limit) ? limit - 1 : v;
   endfunction

   function automatic rsp_type predict_grid_step(req_type item);
      rsp_type       res;
      ant_entry_type ant;
      int            w, h, slot, col, row, idx, next_col, next_row;
      res  = '0;
      w    = usable_dim(int'(grid_cfg.grid_width), MAX_COLS);
      h    = usable_dim(int'(grid_cfg.grid_height), MAX_ROWS);
      slot = int'(item.ant_slot) % ANT_SLOTS;
      col  = clamp_to(int'(item.col_in), w);
      row  = clamp_to(int'(item.row_in), h);
      case (item.mode)
         MODE_LOAD: begin
            ant.col     = col[8:0];
            ant.row     = row[7:0];
            ant.heading = item.heading_in;
            ant_table[slot] = ant;
            res.ant_col     = ant.col;
            res.ant_row     = ant.row;
            res.ant_heading = ant.heading;
            res.cell_col    = ant.col;
            res.cell_row    = ant.row;
            res.cell_black  = cell_black_map[row * MAX_COLS + col];
         end
         MODE_STEP: begin
            ant = ant_table[slot];
            col = clamp_to(int'(ant.col), w);
            row = clamp_to(int'(ant.row), h);
            idx = row * MAX_COLS + col;
            cell_black_map[idx] = !cell_black_map[idx];
            ant.heading = cell_black_map[idx] ? ant.heading + 2'd1 : ant.heading - 2'd1;
            res.cell_col   = col[8:0];
            res.cell_row   = row[7:0];
            res.cell_black = cell_black_map[idx];
            next_col = col;
            next_row = row;
            case (ant.heading)
               HEAD_UP:    next_row--;
               HEAD_RIGHT: next_col++;
               HEAD_DOWN:  next_row++;
               HEAD_LEFT:  next_col--;
            endcase
            if (next_col < 0 || next_col >= w || next_row < 0 || next_row >= h) begin
               res.bounced = 1'b1;
               ant.heading = ant.heading + 2'd2;
               next_col = (next_col < 0) ? 0 : clamp_to(next_col, w);
               next_row = (next_row < 0) ? 0 : clamp_to(next_row, h);
            end
            ant.col = next_col[8:0];
            ant.row = next_row[7:0];
            ant_table[slot] = ant;
            res.ant_col     = ant.col;
            res.ant_row     = ant.row;
            res.ant_heading = ant.heading;
         end
         MODE_READ: begin
            res.cell_col   = col[8:0];
            res.cell_row   = row[7:0];
            res.cell_black = cell_black_map[row * MAX_COLS + col];
         end
         default: ;
      endcase
      return res;
   endfunction

   task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         fail_count++;
         $display("%0t: %s expected %0d, actual %0d", $time, name, exp_v, act_v);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cell_black_map        = '0;
         grid_cfg.grid_width   = GRID_WIDTH_RESET;
         grid_cfg.grid_height  = GRID_HEIGHT_RESET;
         expected_q.delete();
         fail_count   = 0;
         bounce_count = 0;
      end else begin
         if (rsp_strobe) begin
            if (expected_q.size() == 0) begin
               fail_count++;
               $display("%0t: result with no item outstanding, expected none, actual %h",
                        $time, rsp_item);
            end else begin
               oldest = expected_q.pop_front();
               compare_field("ant_col", 32'(oldest.ant_col), 32'(rsp_item.ant_col));
               compare_field("ant_row", 32'(oldest.ant_row), 32'(rsp_item.ant_row));
               compare_field("ant_heading", 32'(oldest.ant_heading),
                             32'(rsp_item.ant_heading));
               compare_field("cell_col", 32'(oldest.cell_col), 32'(rsp_item.cell_col));
               compare_field("cell_row", 32'(oldest.cell_row), 32'(rsp_item.cell_row));
               compare_field("cell_black", 32'(oldest.cell_black),
                             32'(rsp_item.cell_black));
               compare_field("bounced", 32'(oldest.bounced), 32'(rsp_item.bounced));
               if (oldest.bounced) bounce_count++;
            end
         end
         if (start && !busy) expected_q = {expected_q, predict_grid_step(req_item)};
         if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_GRID_WIDTH) grid_cfg.grid_width = pwdata[9:0];
            else if (paddr[2] == REG_GRID_HEIGHT) grid_cfg.grid_height = pwdata[8:0];
         end
      end
      pending_count <= expected_q.size();
   end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
module tb;
   import mant_pkg::*;

   localparam int N_PHASES    = 12;
   localparam int PHASE_ITEMS = 100;
   localparam int RUN_LIMIT   = 300000;
   localparam int MAX_COLS    = 512;
   localparam int MAX_ROWS    = 256;
   localparam int ANT_SLOTS   = 2048;

   localparam logic [1:0] MODE_SPARE       = 2'd3;
   localparam logic [2:0] ADDR_GRID_WIDTH  = {REG_GRID_WIDTH, 2'b00};
   localparam logic [2:0] ADDR_GRID_HEIGHT = {REG_GRID_HEIGHT, 2'b00};

   logic        clock    = 1'b0;
   logic        reset    = 1'b1;
   logic        start    = 1'b0;
   logic        busy;
   req_type     req_item = '0;
   logic        rsp_strobe;
   rsp_type     rsp_item;
   logic        psel     = 1'b0;
   logic        penable  = 1'b0;
   logic        pwrite   = 1'b0;
   logic [2:0]  paddr    = '0;
   logic [31:0] pwdata   = '0;
   logic [31:0] prdata;
   logic        pready;

   int fail_count, pending_count, bounce_count, cycle_count;
   int load_total  = 0;
   int step_total  = 0;
   int read_total  = 0;
   int spare_total = 0;
   int idle_pct    = 0;
   int cur_w       = int'(GRID_WIDTH_RESET);
   int cur_h       = int'(GRID_HEIGHT_RESET);
   int active_slots [$];
   int phase_widths  [N_PHASES] = '{1, 512, 0, 1023, 3, 2, 8, 33, 100, 360, 0, 0};
   int phase_heights [N_PHASES] = '{1, 256, 0, 511, 2, 5, 9, 17, 256, 175, 0, 0};
   int idle_pcts [4] = '{0, 47, 0, 34};

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   multi_ant_langton_grid_step i_dut (.*);

   grid_step_checker i_checker (.*);

   function automatic int usable_dim(int v, int maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   function automatic req_type make_req(logic [1:0] mode, int slot, int col, int row,
                                        logic [1:0] heading);
      req_type r;
      r.mode       = mode;
      r.ant_slot   = slot[10:0];
      r.col_in     = col[8:0];
      r.row_in     = row[7:0];
      r.heading_in = heading;
      return r;
   endfunction

   function automatic req_type random_req(logic [1:0] mode, int slot, bit in_grid);
      req_type r;
      r = make_req(mode, slot, $urandom_range(MAX_COLS - 1), $urandom_range(MAX_ROWS - 1),
                   2'($urandom_range(3)));
      if (in_grid) begin
         r.col_in = 9'($urandom_range(cur_w - 1));
         r.row_in = 8'($urandom_range(cur_h - 1));
      end
      return r;
   endfunction

   task automatic issue_item(input req_type item);
      start    <= 1'b1;
      req_item <= item;
      do @(posedge clock); while (busy);
      case (item.mode)
         MODE_LOAD: load_total++;
         MODE_STEP: step_total++;
         MODE_READ: read_total++;
         default:   spare_total++;
      endcase
   endtask

   task automatic idle_gap;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic drain_items;
      start <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic set_grid(input int width, input int height);
      logic [31:0] words [2];
      logic [2:0]  addrs [2];
      words[0] = ($urandom & 32'hFFFF_FC00) | width;
      words[1] = ($urandom & 32'hFFFF_FE00) | height;
      addrs[0] = ADDR_GRID_WIDTH;
      addrs[1] = ADDR_GRID_HEIGHT;
      for (int i = 0; i < 2; i++) begin
         psel    <= 1'b1;
         penable <= 1'b0;
         pwrite  <= 1'b1;
         paddr   <= addrs[i];
         pwdata  <= words[i];
         @(posedge clock);
         penable <= 1'b1;
         do @(posedge clock); while (!pready);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      cur_w = usable_dim(width, MAX_COLS);
      cur_h = usable_dim(height, MAX_ROWS);
   endtask

   initial begin
      for (cycle_count = 0; cycle_count < RUN_LIMIT; cycle_count++) @(posedge clock);
      $display("tb: failure");
      $finish;
   end

   initial begin
      int w, h, slot, roll, pick;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      issue_item(make_req(MODE_READ, 0, 0, 0, HEAD_UP));
      issue_item(make_req(MODE_LOAD, 0, 0, 0, HEAD_UP));
      repeat (4) issue_item(make_req(MODE_STEP, 0, 0, 0, HEAD_UP));
      issue_item(make_req(MODE_READ, 0, 0, 0, HEAD_UP));
      issue_item(make_req(MODE_STEP, 0, 0, 0, HEAD_UP));
      issue_item(make_req(MODE_LOAD, 2047, 511, 255, HEAD_LEFT));
      issue_item(make_req(MODE_STEP, 2047, 0, 0, HEAD_UP));
      issue_item(make_req(MODE_LOAD, 1, 359, 0, HEAD_UP));
      issue_item(make_req(MODE_STEP, 1, 511, 255, HEAD_LEFT));
      issue_item(make_req(MODE_LOAD, 2, 0, 174, HEAD_DOWN));
      issue_item(make_req(MODE_STEP, 2, 0, 0, HEAD_UP));
      issue_item(make_req(MODE_LOAD, 3, 200, 174, HEAD_RIGHT));
      issue_item(make_req(MODE_STEP, 3, 0, 0, HEAD_UP));
      issue_item(make_req(MODE_LOAD, 4, 200, 0, HEAD_LEFT));
      issue_item(make_req(MODE_STEP, 4, 0, 0, HEAD_UP));
      issue_item(make_req(MODE_READ, 2047, 511, 255, HEAD_LEFT));
      issue_item(make_req(MODE_READ, 0, 1, 1, HEAD_UP));
      issue_item('1);
      issue_item(make_req(MODE_SPARE, 0, 0, 0, HEAD_UP));
      active_slots = {active_slots, 0};
      active_slots = {active_slots, 2047};

      for (int p = 0; p < N_PHASES; p++) begin
         drain_items();
         w = phase_widths[p];
         h = phase_heights[p];
         if (p >= N_PHASES - 2) begin
            w = $urandom_range(1023);
            h = $urandom_range(511);
         end
         set_grid(w, h);
         idle_pct = idle_pcts[p % 4];
         // keep a couple of ants from the last grid, so some start outside the new one
         while (active_slots.size() > 2) void'(active_slots.pop_front());
         repeat ($urandom_range(1, 3)) begin
            pick = $urandom_range(9);
            slot = (pick == 0) ? 0 : (pick == 1) ? ANT_SLOTS - 1 : $urandom_range(ANT_SLOTS - 1);
            idle_gap();
            issue_item(random_req(MODE_LOAD, slot, 1'b1));
            active_slots = {active_slots, slot};
         end
         repeat (PHASE_ITEMS) begin
            idle_gap();
            roll = $urandom_range(99);
            slot = active_slots[$urandom_range(active_slots.size() - 1)];
            if (roll < 6) begin
               if ($urandom_range(1)) begin
                  slot = $urandom_range(ANT_SLOTS - 1);
                  if (active_slots.size() < 6) active_slots = {active_slots, slot};
               end
               issue_item(random_req(MODE_LOAD, slot, 1'($urandom_range(1))));
            end else if (roll < 84) begin
               issue_item(random_req(MODE_STEP, slot, 1'b0));
            end else if (roll < 96) begin
               issue_item(random_req(MODE_READ, slot, $urandom_range(3) != 0));
            end else begin
               issue_item(random_req(MODE_SPARE, $urandom_range(ANT_SLOTS - 1), 1'b0));
            end
         end
      end

      drain_items();
      repeat (8) @(posedge clock);
      $display("summary: %0d loads, %0d steps (%0d hit an edge), %0d cell reads, %0d spare items",
               load_total, step_total, bounce_count, read_total, spare_total);
      $display("summary: %0d grid sizes, 1x1 to 512x256, zero and oversized registers included",
               N_PHASES + 1);
      if (fail_count == 0 && pending_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

FILE: multi_ant_langton_grid_step.f
rtl/mant_pkg.sv
rtl/mant_ram.sv
rtl/mant_seq.sv
rtl/multi_ant_langton_grid_step.sv
verif/grid_step_checker.sv
verif/tb.sv
